// ----- design/pss_pkg.sv -----
// package for the proximity scan sequencer: phase and operation codes,
// register indexes, reset values and stream widths; no dependencies
package pss_pkg;

  typedef enum logic [1:0] {
    PH_DISABLED = 2'd0,
    PH_IDLE     = 2'd1,
    PH_SCANNING = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_ENABLE  = 2'd1,
    OP_DISABLE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_IDLE_CLEAR   = 2'd0,
    REG_IDLE_PRESENT = 2'd1,
    REG_SCAN_TIME    = 2'd2
  } reg_idx_e;

  localparam int unsigned CountW   = 16;
  localparam int unsigned ScanW    = 4;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CountW-1:0] PowerUpDelayMs   = CountW'(100);
  localparam logic [CountW-1:0] IdleClearReset   = CountW'(200);
  localparam logic [CountW-1:0] IdlePresentReset = CountW'(500);
  localparam logic [ScanW-1:0]  ScanTimeReset    = ScanW'(5);

  localparam int unsigned InDataW  = 8;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 8;

endpackage

// ----- design/proximity_scan_sequencer_unit.sv -----
// proximity scan sequencer top level: phase/countdown update and result register
// depends on pss_pkg
//
// the result of an accepted request is registered and shows on the master side in the next cycle
// throughput: one request per cycle; the only hold-up is a full result register
//   that the downstream side does not take (s_axis_tready follows m_axis_tready)
// reset: rst_ni clears phase to disabled, countdown and last reading to zero,
//   the three timing registers to 200, 500 and 5 ms, and empties the result register
module proximity_scan_sequencer_unit
  import pss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [0] detect_level, [7:1] zero
  input  logic [InUserW-1:0]  s_axis_tuser,   // [1:0] operation
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // [0] emitter_drive, [1] sensor_power,
                                              // [2] change_event, [3] reading,
                                              // [5:4] phase, [7:6] zero
);

  // timing registers
  logic [CountW-1:0] idle_clear_q, idle_present_q;
  logic [ScanW-1:0]  scan_time_q;

  // sequencer state
  phase_e            phase_q, phase_d;
  logic [CountW-1:0] ms_q, ms_d;
  logic              last_q, last_d;
  logic              event_d;

  // result register
  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic   accept;
  op_e    op;
  logic   detect;
  logic   active;

  assign op     = op_e'(s_axis_tuser);
  assign detect = s_axis_tdata[0];
  assign active = (phase_q == PH_IDLE) || (phase_q == PH_SCANNING);

  // result register drains or is empty, so a new request can enter
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // configuration writes, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_clear_q   <= IdleClearReset;
      idle_present_q <= IdlePresentReset;
      scan_time_q    <= ScanTimeReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IDLE_CLEAR:   idle_clear_q   <= cfg_data_i[CountW-1:0];
        REG_IDLE_PRESENT: idle_present_q <= cfg_data_i[CountW-1:0];
        REG_SCAN_TIME:    scan_time_q    <= cfg_data_i[ScanW-1:0];
        default: ;
      endcase
    end
  end

  // next state: a count above one is decremented, otherwise it expires
  // (a loaded zero expires on the next tick, like one)
  always_comb begin
    phase_d = phase_q;
    ms_d    = ms_q;
    last_d  = last_q;
    event_d = 1'b0;
    unique case (op)
      OP_TICK: begin
        if (active) begin
          if (ms_q > CountW'(1)) begin
            ms_d = ms_q - CountW'(1);
          end else if (phase_q == PH_IDLE) begin
            phase_d = PH_SCANNING;
            ms_d    = CountW'(scan_time_q);
          end else begin
            // end of scan: sample the detect pin, pick the idle interval
            // from the new reading
            event_d = (detect != last_q);
            last_d  = detect;
            phase_d = PH_IDLE;
            ms_d    = detect ? idle_present_q : idle_clear_q;
          end
        end
      end
      OP_ENABLE: begin
        if (!active) begin
          phase_d = PH_IDLE;
          ms_d    = PowerUpDelayMs;
        end
      end
      OP_DISABLE: begin
        phase_d = PH_DISABLED;
        ms_d    = '0;
      end
      default: ;  // unused operation code, result only
    endcase
  end

  // outputs describe the state after the request
  always_comb begin
    out_data_d = '0;
    unique case (phase_d)
      PH_IDLE: begin
        out_data_d[1]   = 1'b1;
        out_data_d[5:4] = PH_IDLE;
      end
      PH_SCANNING: begin
        out_data_d[0]   = 1'b1;
        out_data_d[1]   = 1'b1;
        out_data_d[5:4] = PH_SCANNING;
      end
      default: ;  // disabled
    endcase
    out_data_d[2] = event_d;
    out_data_d[3] = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DISABLED;
      ms_q    <= '0;
      last_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      ms_q    <= ms_d;
      last_q  <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // disabled always carries a cleared countdown
  a_disabled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DISABLED) |-> (ms_q == '0))
    else $error("countdown not cleared while disabled");

  // an accepted disable leaves the sequencer disabled
  a_disable_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op == OP_DISABLE)) |=> (phase_q == PH_DISABLED))
    else $error("disable request not obeyed");

  // a change event only ever comes with the return to idle
  a_event_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q[2]) |-> (out_data_q[5:4] == PH_IDLE && !out_data_q[0]))
    else $error("change event outside the end of a scan");

  // the reported reading tracks the stored one after each request
  a_reading_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (out_data_q[3] == last_q))
    else $error("reported reading differs from stored reading");

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for proximity_scan_sequencer_unit: a queue of tick and command
// requests is driven in, and every result is checked against a local model of the scan phases
// depends on pss_pkg and the unit itself
module tb;
  import pss_pkg::*;

  // operation code three and register index three exist in the field widths only
  localparam logic [1:0]         OpUnused  = 2'd3;
  localparam logic [CfgIdxW-1:0] RegUnused = CfgIdxW'(3);

  localparam int unsigned GapMax      = 18;
  localparam int unsigned HoldAfter   = 200;   // result count that starts the long stall
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned NumSettings = 8;
  localparam int unsigned DrainCycles = 5;
  // worst correct stretch without a handshake: both sides idle for GapMax around one
  // request, or the HoldCycles receiver hold; a few times that
  localparam int unsigned WatchdogLimit = 1500;

  typedef struct packed {
    logic [1:0] op;
    logic       det;
  } sensor_req_t;

  // result layout, lowest bit last
  typedef struct packed {
    logic [1:0] pad;
    logic [1:0] phase;
    logic       reading;
    logic       change;
    logic       power;
    logic       emitter;
  } sensor_res_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i     = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [0] detect_level, [7:1] zero
  logic [InUserW-1:0]  s_axis_tuser  = '0;   // [1:0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [0] emitter_drive, [1] sensor_power,
                                             // [2] change_event, [3] reading,
                                             // [5:4] phase, [7:6] zero

  proximity_scan_sequencer_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial forever #5 clk_i = ~clk_i;

  // request queue and results still owed by the unit
  sensor_req_t sensor_reqs[$];
  sensor_res_t scan_results_due[$];

  // local copy of the sequencer state and its timing registers
  phase_e            sq_phase        = PH_DISABLED;
  logic [CountW-1:0] sq_remaining    = '0;
  logic              sq_reading      = 1'b0;
  logic [CountW-1:0] sq_idle_clear   = IdleClearReset;
  logic [CountW-1:0] sq_idle_present = IdlePresentReset;
  logic [ScanW-1:0]  sq_scan_time    = ScanTimeReset;

  int unsigned n_req_sent = 0;
  int unsigned n_req_acc  = 0;
  int unsigned n_res      = 0;
  int unsigned n_fail     = 0;
  int unsigned n_scans    = 0;
  int unsigned n_events   = 0;
  int unsigned n_powerups = 0;
  int unsigned n_settings = 0;
  int unsigned tx_gap     = 0;
  int unsigned rx_gap     = 0;
  int unsigned rx_hold    = 0;
  int unsigned stall_cnt  = 0;
  int unsigned gap_max    = GapMax;
  bit          gen_on     = 1'b0;   // whether the generator believes detection is on

  // one request applied to the local state; returns the result the unit owes for it
  function automatic sensor_res_t advance_scan(logic [1:0] op, logic det);
    sensor_res_t res;
    logic        active;
    res    = '0;
    active = (sq_phase == PH_IDLE) || (sq_phase == PH_SCANNING);
    case (op)
      OP_TICK: begin
        // ticks only count while idle or scanning
        if (active) begin
          if (sq_remaining > CountW'(1)) begin
            sq_remaining = sq_remaining - CountW'(1);
          end else if (sq_phase == PH_IDLE) begin
            // a zero count expires on the next tick, same as one
            sq_phase     = PH_SCANNING;
            sq_remaining = CountW'(sq_scan_time);
          end else begin
            // end of the emitter pulse: sample the pin, flag a change
            if (det != sq_reading) begin
              res.change = 1'b1;
              sq_reading = det;
              n_events++;
            end
            n_scans++;
            sq_phase     = PH_IDLE;
            sq_remaining = sq_reading ? sq_idle_present : sq_idle_clear;
          end
        end
      end
      OP_ENABLE: begin
        // enable while already running keeps phase and countdown
        if (!active) begin
          sq_phase     = PH_IDLE;
          sq_remaining = PowerUpDelayMs;
          n_powerups++;
        end
      end
      OP_DISABLE: begin
        // last reading survives a disable
        sq_phase     = PH_DISABLED;
        sq_remaining = '0;
      end
      default: begin
        // unused code: result only
      end
    endcase
    active      = (sq_phase == PH_IDLE) || (sq_phase == PH_SCANNING);
    res.emitter = (sq_phase == PH_SCANNING);
    res.power   = active;
    res.reading = sq_reading;
    res.phase   = active ? sq_phase : PH_DISABLED;
    return res;
  endfunction

  // register writes and accepted requests, both seen at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IDLE_CLEAR:   sq_idle_clear   = cfg_data_i;
          REG_IDLE_PRESENT: sq_idle_present = cfg_data_i;
          REG_SCAN_TIME:    sq_scan_time    = cfg_data_i[ScanW-1:0];
          default: begin
          end
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        scan_results_due.push_back(advance_scan(s_axis_tuser, s_axis_tdata[0]));
        n_req_acc++;
      end
    end
  end

  // request driver: a new request once the previous one has gone and its gap has run out
  always @(negedge clk_i) begin
    sensor_req_t req;
    if (rst_ni) begin
      if (n_req_acc == n_req_sent) begin
        if (tx_gap > 0 || sensor_reqs.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          s_axis_tvalid <= 1'b0;
        end else begin
          req = sensor_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= req.op;
          s_axis_tdata  <= InDataW'(req.det);
          n_req_sent++;
          tx_gap = $urandom_range(0, gap_max);
        end
      end
    end
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  // result monitor: every accepted result against the oldest one owed
  always @(posedge clk_i) begin
    sensor_res_t got;
    sensor_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      n_res++;
      if (scan_results_due.size() == 0) begin
        $error("result 0x%h arrived with no request outstanding", got);
        n_fail++;
      end else begin
        want = scan_results_due.pop_front();
        check_field("emitter_drive", 32'(want.emitter), 32'(got.emitter));
        check_field("sensor_power", 32'(want.power), 32'(got.power));
        check_field("change_event", 32'(want.change), 32'(got.change));
        check_field("reading", 32'(want.reading), 32'(got.reading));
        check_field("phase", 32'(want.phase), 32'(got.phase));
        check_field("padding", 32'(want.pad), 32'(got.pad));
      end
      rx_gap = $urandom_range(0, gap_max);
      // one long hold so the result register fills and the input side stalls
      if (n_res == HoldAfter) rx_hold = HoldCycles;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
      if (stall_cnt >= WatchdogLimit) begin
        $display("no handshake for %0d cycles, %0d results still owed",
                 stall_cnt, scan_results_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic push_req(logic [1:0] op, logic det);
    sensor_req_t req;
    req.op  = op;
    req.det = det;
    sensor_reqs.push_back(req);
  endtask

  // mostly ticks with a random pin; rare disables, enables soon after one
  task automatic queue_random(int unsigned count, int unsigned dis_pm);
    sensor_req_t req;
    int unsigned roll;
    repeat (count) begin
      roll    = $urandom_range(0, 999);
      req.det = 1'($urandom_range(0, 1));
      if (roll < dis_pm) req.op = OP_DISABLE;
      else if (roll < dis_pm + (gen_on ? 10 : 300)) req.op = OP_ENABLE;
      else if (roll < dis_pm + (gen_on ? 20 : 310)) req.op = OpUnused;
      else req.op = OP_TICK;
      if (req.op == OP_ENABLE) gen_on = 1'b1;
      else if (req.op == OP_DISABLE) gen_on = 1'b0;
      sensor_reqs.push_back(req);
    end
  endtask

  // every request owes exactly one result, so idle means nothing queued or owed
  task automatic wait_drained();
    do @(posedge clk_i);
    while (sensor_reqs.size() != 0 || n_req_acc != n_req_sent || scan_results_due.size() != 0);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic set_regs(logic [CountW-1:0] clear, logic [CountW-1:0] present,
                          logic [ScanW-1:0] scan);
    write_reg(REG_IDLE_CLEAR, clear);
    write_reg(REG_IDLE_PRESENT, present);
    write_reg(REG_SCAN_TIME, CfgDataW'(scan));
    n_settings++;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed opening on the reset timing values
    push_req(OP_TICK, 1'b1);      // tick while disabled is ignored
    push_req(OpUnused, 1'b1);     // unused operation code
    push_req(OP_DISABLE, 1'b0);   // disable while already disabled
    push_req(OP_ENABLE, 1'b0);    // power-up delay loaded
    push_req(OP_ENABLE, 1'b1);    // second enable keeps the countdown
    push_req(OP_TICK, 1'b0);
    push_req(OP_TICK, 1'b1);
    push_req(OpUnused, 1'b0);
    push_req(OP_DISABLE, 1'b1);   // disable mid power-up
    push_req(OP_TICK, 1'b0);
    push_req(OP_ENABLE, 1'b1);
    gen_on = 1'b1;
    // long enough to get through power-up, one idle interval and a scan
    queue_random(320, 2);
    wait_drained();

    for (int ph = 0; ph < NumSettings; ph++) begin
      case (ph)
        0: begin
          // zero clear interval, a present interval of one and zero scan time, plus a write to the spare index
          set_regs(16'd0, 16'd1, 4'd0);
          write_reg(RegUnused, 16'hFFFF);
        end
        1: set_regs(16'd50, 16'hFFFF, 4'd10);   // range extremes
        2: set_regs(16'hFFFF, 16'd50, 4'd1);
        3: set_regs(16'd3, 16'd7, 4'd15);       // scan times above ten
        4: set_regs(16'd1, 16'd2, 4'd11);
        default: begin
          set_regs(CountW'($urandom_range(1, 20)), CountW'($urandom_range(1, 20)),
                   ScanW'($urandom_range(0, 15)));
        end
      endcase
      // two settings run without any idling on either side
      gap_max = (ph == 3 || ph == 6) ? 0 : GapMax;
      queue_random(100, 4);
      // a 64k countdown would hold up later settings: stop it here
      if (ph == 1 || ph == 2) begin
        push_req(OP_DISABLE, 1'b0);
        gen_on = 1'b0;
      end
      wait_drained();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (scan_results_due.size() != 0) begin
      $error("%0d results never arrived", scan_results_due.size());
      n_fail++;
    end
    $display("%0d requests and %0d results checked over %0d timing settings",
             n_req_acc, n_res, n_settings + 1);
    $display("%0d power-ups, %0d completed scans, %0d change events",
             n_powerups, n_scans, n_events);
    if (n_fail == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- proximity_scan_sequencer_unit.f -----
design/pss_pkg.sv
design/proximity_scan_sequencer_unit.sv
verif/tb.sv
